// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the overlap partition block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define OVP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define OVP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ovp_pkg.sv
// Package with the types and constants of the overlap partition block.
package ovp_pkg;

    localparam int ID_W  = 31;
    localparam int CRD_W = 24;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIN_START = 2'd0,
        CFG_WIN_END   = 2'd1,
        CFG_BATCH     = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [ID_W-1:0]  query_id;
        logic [CRD_W-1:0] query_length;
        logic [CRD_W-1:0] query_offset;
        logic [CRD_W-1:0] query_end;
        logic [CRD_W-1:0] query_extension;
        logic             query_strand;
        logic [ID_W-1:0]  subject_id;
        logic [CRD_W-1:0] subject_length;
        logic [CRD_W-1:0] subject_offset;
        logic [CRD_W-1:0] subject_end;
        logic [CRD_W-1:0] subject_extension;
        logic             subject_strand;
    } t_in_req;

    typedef struct packed {
        logic [ID_W-1:0]    partition_index;
        logic               last_copy;
        logic [ID_W-1:0]    out_query_id;
        logic [ID_W-1:0]    out_subject_id;
        logic [2*CRD_W-1:0] out_lengths;
        logic [CRD_W-1:0]   out_query_offset;
        logic [CRD_W-1:0]   out_query_end;
        logic [CRD_W-1:0]   out_query_extension;
        logic               out_query_strand;
        logic [CRD_W-1:0]   out_subject_offset;
        logic [CRD_W-1:0]   out_subject_end;
        logic [CRD_W-1:0]   out_subject_extension;
    } t_out_req;

    typedef struct packed {
        logic [ID_W-1:0]  qid;
        logic [ID_W-1:0]  sid;
        logic [CRD_W-1:0] qlen;
        logic [CRD_W-1:0] slen;
        logic [CRD_W-1:0] qoff;
        logic [CRD_W-1:0] qend;
        logic [CRD_W-1:0] qext;
        logic             qstr;
        logic [CRD_W-1:0] soff;
        logic [CRD_W-1:0] send;
        logic [CRD_W-1:0] sext;
    } t_copy;

    typedef struct packed {
        t_copy copy_a;
        t_copy copy_b;
        logic  q_in;
        logic  s_in;
    } t_mid;

endpackage

// File: src/ovp_front.sv
// Front stage: window test, offset from window start and coordinate mirroring.
module ovp_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  ovp_pkg::t_in_req           i_req,
    input  logic [ovp_pkg::ID_W-1:0]   i_win_start,
    input  logic [ovp_pkg::ID_W-1:0]   i_win_end,
    output logic                       o_valid,
    output ovp_pkg::t_mid              o_mid,
    output logic [ovp_pkg::ID_W-1:0]   o_dq,
    output logic [ovp_pkg::ID_W-1:0]   o_ds
);

    logic                       r_valid;
    ovp_pkg::t_mid              r_mid;
    logic [ovp_pkg::ID_W-1:0]   r_dq;
    logic [ovp_pkg::ID_W-1:0]   r_ds;
    ovp_pkg::t_mid              n_mid;
    logic                       q_in;
    logic                       s_in;
    logic [ovp_pkg::CRD_W-1:0]  q_off;
    logic [ovp_pkg::CRD_W-1:0]  q_end;
    logic [ovp_pkg::CRD_W-1:0]  q_ext;
    logic [ovp_pkg::CRD_W-1:0]  s_off;
    logic [ovp_pkg::CRD_W-1:0]  s_end;
    logic [ovp_pkg::CRD_W-1:0]  s_ext;
    logic [ovp_pkg::CRD_W-1:0]  mq_off;
    logic [ovp_pkg::CRD_W-1:0]  mq_end;
    logic [ovp_pkg::CRD_W-1:0]  mq_ext;
    logic [ovp_pkg::CRD_W-1:0]  ms_off;
    logic [ovp_pkg::CRD_W-1:0]  ms_end;
    logic [ovp_pkg::CRD_W-1:0]  ms_ext;
    logic                       rel_str;

    always_comb begin
        q_off = i_req.query_offset;
        q_end = i_req.query_end;
        q_ext = i_req.query_extension;
        s_off = i_req.subject_offset;
        s_end = i_req.subject_end;
        s_ext = i_req.subject_extension;
        mq_off = i_req.query_length - q_end;
        mq_end = i_req.query_length - q_off;
        mq_ext = i_req.query_length - ovp_pkg::CRD_W'(1) - q_ext;
        ms_off = i_req.subject_length - s_end;
        ms_end = i_req.subject_length - s_off;
        ms_ext = i_req.subject_length - ovp_pkg::CRD_W'(1) - s_ext;
        rel_str = i_req.query_strand ^ i_req.subject_strand;
        q_in = (i_req.query_id >= i_win_start) && (i_req.query_id < i_win_end);
        s_in = (i_req.subject_id >= i_win_start) && (i_req.subject_id < i_win_end);

        n_mid.q_in = q_in;
        n_mid.s_in = s_in;

        n_mid.copy_a.qid  = i_req.subject_id;
        n_mid.copy_a.sid  = i_req.query_id;
        n_mid.copy_a.qlen = i_req.subject_length;
        n_mid.copy_a.slen = i_req.query_length;
        n_mid.copy_a.qstr = rel_str;
        n_mid.copy_a.qoff = i_req.query_strand ? ms_off : s_off;
        n_mid.copy_a.qend = i_req.query_strand ? ms_end : s_end;
        n_mid.copy_a.qext = i_req.query_strand ? ms_ext : s_ext;
        n_mid.copy_a.soff = i_req.query_strand ? mq_off : q_off;
        n_mid.copy_a.send = i_req.query_strand ? mq_end : q_end;
        n_mid.copy_a.sext = i_req.query_strand ? mq_ext : q_ext;

        n_mid.copy_b.qid  = i_req.query_id;
        n_mid.copy_b.sid  = i_req.subject_id;
        n_mid.copy_b.qlen = i_req.query_length;
        n_mid.copy_b.slen = i_req.subject_length;
        n_mid.copy_b.qstr = rel_str;
        n_mid.copy_b.qoff = i_req.subject_strand ? mq_off : q_off;
        n_mid.copy_b.qend = i_req.subject_strand ? mq_end : q_end;
        n_mid.copy_b.qext = i_req.subject_strand ? mq_ext : q_ext;
        n_mid.copy_b.soff = i_req.subject_strand ? ms_off : s_off;
        n_mid.copy_b.send = i_req.subject_strand ? ms_end : s_end;
        n_mid.copy_b.sext = i_req.subject_strand ? ms_ext : s_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid && (q_in || s_in);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mid <= n_mid;
            r_dq  <= i_req.query_id - i_win_start;
            r_ds  <= i_req.subject_id - i_win_start;
        end
    end

    assign o_valid = r_valid;
    assign o_mid   = r_mid;
    assign o_dq    = r_dq;
    assign o_ds    = r_ds;

endmodule

// File: src/ovp_div.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes.
module ovp_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  ovp_pkg::t_mid              i_mid,
    input  logic [ovp_pkg::ID_W-1:0]   i_dq,
    input  logic [ovp_pkg::ID_W-1:0]   i_ds,
    input  logic [ovp_pkg::ID_W-1:0]   i_divisor,
    output logic                       o_valid,
    output ovp_pkg::t_mid              o_mid,
    output logic [ovp_pkg::ID_W-1:0]   o_pq,
    output logic [ovp_pkg::ID_W-1:0]   o_ps
);

    localparam int W = ovp_pkg::ID_W;

    function automatic logic [2*W-1:0] div_step(input logic [W-1:0] rem,
                                               input logic [W-1:0] w,
                                               input logic [W-1:0] d);
        logic [W:0] t;
        logic [W:0] diff;
        t    = {rem, w[W-1]};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            return {diff[W-1:0], w[W-2:0], 1'b1};
        end else begin
            return {t[W-1:0], w[W-2:0], 1'b0};
        end
    endfunction

    logic          r_v   [W];
    ovp_pkg::t_mid r_m   [W];
    logic [W-1:0]  r_rq  [W];
    logic [W-1:0]  r_wq  [W];
    logic [W-1:0]  r_rs  [W];
    logic [W-1:0]  r_ws  [W];

    for (genvar g = 0; g < W; g++) begin : g_stage
        logic          v_in;
        ovp_pkg::t_mid m_in;
        logic [W-1:0]  rq_in;
        logic [W-1:0]  wq_in;
        logic [W-1:0]  rs_in;
        logic [W-1:0]  ws_in;
        logic [2*W-1:0] n_q;
        logic [2*W-1:0] n_s;

        if (g == 0) begin : g_first
            assign v_in  = i_valid;
            assign m_in  = i_mid;
            assign rq_in = '0;
            assign wq_in = i_dq;
            assign rs_in = '0;
            assign ws_in = i_ds;
        end else begin : g_next
            assign v_in  = r_v[g-1];
            assign m_in  = r_m[g-1];
            assign rq_in = r_rq[g-1];
            assign wq_in = r_wq[g-1];
            assign rs_in = r_rs[g-1];
            assign ws_in = r_ws[g-1];
        end

        assign n_q = div_step(rq_in, wq_in, i_divisor);
        assign n_s = div_step(rs_in, ws_in, i_divisor);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[g]  <= m_in;
                r_rq[g] <= n_q[2*W-1:W];
                r_wq[g] <= n_q[W-1:0];
                r_rs[g] <= n_s[2*W-1:W];
                r_ws[g] <= n_s[W-1:0];
            end
        end
    end

    assign o_valid = r_v[W-1];
    assign o_mid   = r_m[W-1];
    assign o_pq    = r_wq[W-1];
    assign o_ps    = r_ws[W-1];

endmodule

// File: src/ovp_emit.sv
// Output stage: holds one record and sends its one or two copies in order.
module ovp_emit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  ovp_pkg::t_mid              i_mid,
    input  logic [ovp_pkg::ID_W-1:0]   i_pq,
    input  logic [ovp_pkg::ID_W-1:0]   i_ps,
    input  logic                       i_stall,
    output logic                       o_ready,
    output logic                       o_valid,
    output ovp_pkg::t_out_req          o_req
);

    logic                       r_pa;
    logic                       r_pb;
    ovp_pkg::t_copy             r_ca;
    ovp_pkg::t_copy             r_cb;
    logic [ovp_pkg::ID_W-1:0]   r_pq;
    logic [ovp_pkg::ID_W-1:0]   r_ps;
    logic                       take;
    logic                       load;
    ovp_pkg::t_copy             cur;

    assign take    = o_valid && !i_stall;
    assign o_ready = !(r_pa || r_pb) || (take && (r_pa ^ r_pb));
    assign load    = i_valid && o_ready;
    assign o_valid = r_pa || r_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pa <= 1'b0;
            r_pb <= 1'b0;
        end else if (load) begin
            r_pa <= i_mid.q_in;
            r_pb <= i_mid.s_in;
        end else if (take) begin
            if (r_pa) begin
                r_pa <= 1'b0;
            end else begin
                r_pb <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ca <= i_mid.copy_a;
            r_cb <= i_mid.copy_b;
            r_pq <= i_pq;
            r_ps <= i_ps;
        end
    end

    always_comb begin
        cur = r_pa ? r_ca : r_cb;
        o_req.partition_index       = r_pa ? r_pq : r_ps;
        o_req.last_copy             = !(r_pa && r_pb);
        o_req.out_query_id          = cur.qid;
        o_req.out_subject_id        = cur.sid;
        o_req.out_lengths           = {cur.qlen, cur.slen};
        o_req.out_query_offset      = cur.qoff;
        o_req.out_query_end         = cur.qend;
        o_req.out_query_extension   = cur.qext;
        o_req.out_query_strand      = cur.qstr;
        o_req.out_subject_offset    = cur.soff;
        o_req.out_subject_end       = cur.send;
        o_req.out_subject_extension = cur.sext;
    end

endmodule

// File: src/overlap_record_orient_partition_top.sv
// Top level of the overlap record orientation and partition block.
//
//   channel   direction  handshake            payload
//   request   in         i_valid / o_stall    i_req  (ovp_pkg::t_in_req)
//   result    out        o_valid / i_stall    o_req  (ovp_pkg::t_out_req)
//   config    in         i_cfg_wr_en          i_cfg_index, i_cfg_data
//
// A request enters every cycle while o_stall is low; it passes through the front stage
// and the divider pipeline, one quotient bit per stage, before reaching the output stage.
// A request with both reads in the window sends two copies, one after the other.
// Records with no copy leave the pipeline early.
// The pipeline advances as a whole; o_stall rises only when the output stage is full.
// Reset is synchronous; it clears the valid bits and sets the configuration registers to their reset values.
module overlap_record_orient_partition_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  ovp_pkg::t_in_req              i_req,
    output logic                          o_valid,
    input  logic                          i_stall,
    output ovp_pkg::t_out_req             o_req,
    input  logic                          i_cfg_wr_en,
    input  logic [ovp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ovp_pkg::ID_W-1:0]      i_cfg_data
);

`include "assert_macros.svh"

    logic [ovp_pkg::ID_W-1:0]   r_win_start;
    logic [ovp_pkg::ID_W-1:0]   r_win_end;
    logic [ovp_pkg::ID_W-1:0]   r_batch;
    logic                       en;
    logic                       f_valid;
    ovp_pkg::t_mid              f_mid;
    logic [ovp_pkg::ID_W-1:0]   f_dq;
    logic [ovp_pkg::ID_W-1:0]   f_ds;
    logic                       d_valid;
    ovp_pkg::t_mid              d_mid;
    logic [ovp_pkg::ID_W-1:0]   d_pq;
    logic [ovp_pkg::ID_W-1:0]   d_ps;
    logic                       e_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_start <= '0;
            r_win_end   <= '0;
            r_batch     <= ovp_pkg::ID_W'(1);
        end else if (i_cfg_wr_en) begin
            unique case (ovp_pkg::t_cfg_idx'(i_cfg_index))
                ovp_pkg::CFG_WIN_START: r_win_start <= i_cfg_data;
                ovp_pkg::CFG_WIN_END:   r_win_end   <= i_cfg_data;
                ovp_pkg::CFG_BATCH:
                    r_batch <= (i_cfg_data == '0) ? ovp_pkg::ID_W'(1) : i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en      = e_ready || !d_valid;
    assign o_stall = !en;

    ovp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_valid),
        .i_req       (i_req),
        .i_win_start (r_win_start),
        .i_win_end   (r_win_end),
        .o_valid     (f_valid),
        .o_mid       (f_mid),
        .o_dq        (f_dq),
        .o_ds        (f_ds)
    );

    ovp_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (f_valid),
        .i_mid     (f_mid),
        .i_dq      (f_dq),
        .i_ds      (f_ds),
        .i_divisor (r_batch),
        .o_valid   (d_valid),
        .o_mid     (d_mid),
        .o_pq      (d_pq),
        .o_ps      (d_ps)
    );

    ovp_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .i_mid   (d_mid),
        .i_pq    (d_pq),
        .i_ps    (d_ps),
        .i_stall (i_stall),
        .o_ready (e_ready),
        .o_valid (o_valid),
        .o_req   (o_req)
    );

    `OVP_ASSERT_NXT(a_second_copy, i_clk, i_rst_n, o_valid && !i_stall && !o_req.last_copy, o_valid && o_req.last_copy, "second copy missing after first copy")
    `OVP_ASSERT_IMP(a_no_stall_empty, i_clk, i_rst_n, !o_valid, !o_stall, "input stalled while output stage is empty")
    `OVP_ASSERT_IMP(a_batch_nonzero, i_clk, i_rst_n, 1'b1, r_batch != '0, "divisor register holds zero")

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the overlap record orientation and partition block.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_stall;
    ovp_pkg::t_in_req  i_req;
    logic           o_valid;
    logic           i_stall;
    ovp_pkg::t_out_req o_req;
    logic           i_cfg_wr_en;
    logic [ovp_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [ovp_pkg::ID_W-1:0] i_cfg_data;

    ovp_pkg::t_in_req  pending_records[$];
    ovp_pkg::t_out_req expected_copies[$];

    logic [ovp_pkg::ID_W-1:0] win_start;
    logic [ovp_pkg::ID_W-1:0] win_end;
    logic [ovp_pkg::ID_W-1:0] batch;

    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_off_cycles;
    int  idle_cycles;
    int  errors;
    bit  stim_done;

    overlap_record_orient_partition_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_req(i_req),
        .o_valid(o_valid), .i_stall(i_stall), .o_req(o_req),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic ovp_pkg::t_out_req orient_copy(logic [ovp_pkg::ID_W-1:0] part,
            logic last,
            logic [ovp_pkg::ID_W-1:0] qid, logic [ovp_pkg::CRD_W-1:0] qlen,
            logic [ovp_pkg::CRD_W-1:0] qoff, logic [ovp_pkg::CRD_W-1:0] qend,
            logic [ovp_pkg::CRD_W-1:0] qext, logic qstr,
            logic [ovp_pkg::ID_W-1:0] sid, logic [ovp_pkg::CRD_W-1:0] slen,
            logic [ovp_pkg::CRD_W-1:0] soff, logic [ovp_pkg::CRD_W-1:0] send,
            logic [ovp_pkg::CRD_W-1:0] sext, logic sstr);
        ovp_pkg::t_out_req c;
        c.partition_index = part;
        c.last_copy = last;
        c.out_query_id = qid;
        c.out_subject_id = sid;
        c.out_lengths = {qlen, slen};
        if (sstr) begin
            c.out_query_offset = qlen - qend;
            c.out_query_end = qlen - qoff;
            c.out_query_extension = qlen - 24'd1 - qext;
            c.out_query_strand = ~qstr;
            c.out_subject_offset = slen - send;
            c.out_subject_end = slen - soff;
            c.out_subject_extension = slen - 24'd1 - sext;
        end else begin
            c.out_query_offset = qoff;
            c.out_query_end = qend;
            c.out_query_extension = qext;
            c.out_query_strand = qstr;
            c.out_subject_offset = soff;
            c.out_subject_end = send;
            c.out_subject_extension = sext;
        end
        return c;
    endfunction

    function automatic logic [ovp_pkg::ID_W-1:0] partition_of(logic [ovp_pkg::ID_W-1:0] id);
        logic [ovp_pkg::ID_W-1:0] d;
        d = (batch == '0) ? ovp_pkg::ID_W'(1) : batch;
        return (id - win_start) / d;
    endfunction

    task automatic predict_copies(ovp_pkg::t_in_req r);
        bit q_in;
        bit s_in;
        q_in = r.query_id >= win_start && r.query_id < win_end;
        s_in = r.subject_id >= win_start && r.subject_id < win_end;
        if (q_in)
            expected_copies.push_back(orient_copy(partition_of(r.query_id), !s_in,
                r.subject_id, r.subject_length, r.subject_offset, r.subject_end,
                r.subject_extension, r.subject_strand,
                r.query_id, r.query_length, r.query_offset, r.query_end,
                r.query_extension, r.query_strand));
        if (s_in)
            expected_copies.push_back(orient_copy(partition_of(r.subject_id), 1'b1,
                r.query_id, r.query_length, r.query_offset, r.query_end,
                r.query_extension, r.query_strand,
                r.subject_id, r.subject_length, r.subject_offset, r.subject_end,
                r.subject_extension, r.subject_strand));
    endtask

    // Driver: offers queued records, predicts copies on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_copies(i_req);
                void'(pending_records.pop_front());
            end
            if (!i_valid || !o_stall) begin
                if (pending_records.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_req <= pending_records[0];
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall and result checking.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_copies.size() == 0) begin
                    $display("%0t: unexpected copy %h", $time, o_req);
                    errors++;
                end else begin
                    ovp_pkg::t_out_req e;
                    e = expected_copies.pop_front();
                    if (e !== o_req) begin
                        $display("%0t: expected %p", $time, e);
                        $display("%0t: actual   %p", $time, o_req);
                        errors++;
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Watchdog on lack of progress.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || stim_done
                || (pending_records.size() == 0 && expected_copies.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(ovp_pkg::t_cfg_idx idx, logic [ovp_pkg::ID_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            ovp_pkg::CFG_WIN_START: win_start = value;
            ovp_pkg::CFG_WIN_END:   win_end = value;
            default:                batch = value;
        endcase
    endtask

    task automatic configure(logic [ovp_pkg::ID_W-1:0] s, logic [ovp_pkg::ID_W-1:0] e,
            logic [ovp_pkg::ID_W-1:0] b);
        write_reg(ovp_pkg::CFG_WIN_START, s);
        write_reg(ovp_pkg::CFG_WIN_END, e);
        write_reg(ovp_pkg::CFG_BATCH, b);
    endtask

    task automatic wait_idle();
        while (pending_records.size() != 0 || expected_copies.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [ovp_pkg::ID_W-1:0] pick_id();
        int k;
        k = $urandom_range(9);
        if (k < 7)
            return ovp_pkg::ID_W'(win_start + $urandom_range(2 * (win_end - win_start) + 3) - 2);
        if (k == 7) return ovp_pkg::ID_W'($urandom);
        return (k == 8) ? '0 : {ovp_pkg::ID_W{1'b1}};
    endfunction

    function automatic logic [ovp_pkg::CRD_W-1:0] pick_coord(logic [ovp_pkg::CRD_W-1:0] len);
        int k;
        k = $urandom_range(9);
        if (k < 7) return (len == '0) ? '0 : ovp_pkg::CRD_W'($urandom_range(len));
        if (k == 7) return ovp_pkg::CRD_W'($urandom);
        return (k == 8) ? '0 : {ovp_pkg::CRD_W{1'b1}};
    endfunction

    function automatic ovp_pkg::t_in_req random_record();
        ovp_pkg::t_in_req r;
        r.query_id = pick_id();
        r.subject_id = pick_id();
        r.query_length = ($urandom_range(9) == 0) ? ovp_pkg::CRD_W'($urandom)
                                                  : ovp_pkg::CRD_W'($urandom_range(5000));
        r.subject_length = ($urandom_range(9) == 0) ? ovp_pkg::CRD_W'($urandom)
                                                    : ovp_pkg::CRD_W'($urandom_range(5000));
        r.query_offset = pick_coord(r.query_length);
        r.query_end = pick_coord(r.query_length);
        r.query_extension = pick_coord(r.query_length);
        r.subject_offset = pick_coord(r.subject_length);
        r.subject_end = pick_coord(r.subject_length);
        r.subject_extension = pick_coord(r.subject_length);
        r.query_strand = 1'($urandom_range(1));
        r.subject_strand = 1'($urandom_range(1));
        return r;
    endfunction

    task automatic run_phase(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) pending_records.push_back(random_record());
        wait_idle();
    endtask

    initial begin
        ovp_pkg::t_in_req r;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_req = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = ovp_pkg::CFG_WIN_START;
        i_cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        idle_cycles = 0;
        errors = 0;
        stim_done = 0;
        win_start = 0;
        win_end = 0;
        batch = 1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty window after reset: no copies at all.
        repeat (3) pending_records.push_back(random_record());
        wait_idle();

        // Directed: both in window, each alone, neither, extremes and wraps.
        configure(100, 200, 7);
        r = '0;
        r.query_id = 100; r.subject_id = 199;
        r.query_length = 10; r.query_offset = 2; r.query_end = 9; r.query_extension = 4;
        r.subject_length = 20; r.subject_offset = 1; r.subject_end = 15;
        r.subject_extension = 3;
        for (int m = 0; m < 4; m++) begin
            r.query_strand = m[0]; r.subject_strand = m[1];
            pending_records.push_back(r);
        end
        r.query_id = 150; r.subject_id = 200; pending_records.push_back(r);
        r.query_id = 99; r.subject_id = 120; pending_records.push_back(r);
        r.query_id = 0; r.subject_id = {ovp_pkg::ID_W{1'b1}}; pending_records.push_back(r);
        r = '1;
        r.query_id = 101; r.subject_id = 102; pending_records.push_back(r);
        r = '0;
        r.query_id = 101; r.subject_id = 102; r.query_strand = 1; r.subject_strand = 1;
        pending_records.push_back(r);
        r.query_length = 5; r.query_end = 9; r.query_offset = 7; r.query_extension = 9;
        pending_records.push_back(r);
        wait_idle();

        configure(0, {ovp_pkg::ID_W{1'b1}}, 0);
        r = '1; r.query_id = 0; r.subject_id = {ovp_pkg::ID_W{1'b1}} - 1;
        pending_records.push_back(r);
        wait_idle();
        configure({ovp_pkg::ID_W{1'b1}} - 3, {ovp_pkg::ID_W{1'b1}}, {ovp_pkg::ID_W{1'b1}});
        r.query_id = {ovp_pkg::ID_W{1'b1}} - 1; r.subject_id = {ovp_pkg::ID_W{1'b1}} - 3;
        pending_records.push_back(r);
        wait_idle();
        configure(50, 50, 3);
        pending_records.push_back(random_record());
        wait_idle();

        configure(1000, 1400, 16);
        run_phase(300, 0, 0);
        configure(20, 60, 1);
        run_phase(300, 68, 0);
        configure(5000, 9000, 1000);
        run_phase(300, 0, 68);

        // Long receiver hold-off so the pipeline fills and stalls its input.
        hold_off_cycles = 200;
        run_phase(150, 0, 0);

        configure(ovp_pkg::ID_W'($urandom), {ovp_pkg::ID_W{1'b1}},
                  ovp_pkg::ID_W'($urandom_range(100) + 1));
        configure(0, 300, 0);
        run_phase(200, 12, 12);

        stim_done = 1;
        if (errors == 0 && expected_copies.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
